// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the bitmap block allocator: word layouts,
// status and action codes, unit mark encoding and the size class function
// ----------------------------------------------------------------------------
package bba_pkg;

  // fixed field widths
  localparam int unsigned AddrW    = 10;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned NumClass = 7;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LARGEST_SIZE = 3'd7;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // unit marks: bit 0 used, bit 1 continues into the next unit
  localparam int unsigned MarkUsedBit = 0;
  localparam int unsigned MarkContBit = 1;
  localparam logic [1:0] MARK_FREE      = 2'b00;
  localparam logic [1:0] MARK_USED      = 2'b01;
  localparam logic [1:0] MARK_USED_CONT = 2'b11;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_ROOM   = 2'd2,
    STATUS_NULL_FREE = 2'd3
  } status_e;

  typedef struct packed {
    logic             action;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] block_address;
    logic             address_present;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] granted_address;
  } out_word_t;

  // ceiling of log2 of the size, capped at the last class
  function automatic logic [ClassW-1:0] size_class(input logic [SizeW-1:0] size);
    logic [ClassW-1:0] cls;
    cls = '0;
    for (int c = 0; c < NumClass - 1; c++) begin
      if ((SizeW'(1) << c) < size) begin
        cls = ClassW'(c + 1);
      end
    end
    return cls;
  endfunction

endpackage

// ===== sv/bitmap_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit heap allocator over a mark store of two bits per unit
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o / in_data_i) takes one word per
//   request: an allocate with a size, or a free of a block's first unit
//   output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one word per request: status and the granted first unit
//   config channel (cfg_valid_i / cfg_ready_o) writes the per-class search
//   start units and the largest grantable size; always ready, write only
//   while no request is in flight
// timing:
//   the mark store has one read and one write port; scans stream one unit
//   per cycle through the registered read port
//   an allocate passes through prime, scan, mark (only when granted) and fin;
//   a free through prime, scan and fin; rejected requests go straight to fin
//   one request at a time; in_ready_o is high only while the sequencer idles
// reset:
//   a clearing pass writes every unit free with in_ready_o low; config
//   writes are taken during the pass
// stalls:
//   a finished word waits in the output register; the next request may
//   be taken meanwhile and its result waits until the register frees up
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned HEAP_UNITS  = 1024,
  parameter int unsigned MAX_REQUEST = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_data_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_data_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // unit index width and a position width that holds any start unit plus
  // a size without overflow
  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned PW = ((AW > AddrW) ? AW : AddrW) + 1;
  localparam logic [PW-1:0]    HeapP   = PW'(HEAP_UNITS);
  localparam logic [PW-1:0]    HeapLast = PW'(HEAP_UNITS - 1);
  localparam logic [SizeW-1:0] MaxReq  = SizeW'(MAX_REQUEST);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // reset clearing pass
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] ST_PRIME = 3'd2;  // first read in flight
  localparam logic [2:0] ST_SCAN  = 3'd3;  // one unit checked per cycle
  localparam logic [2:0] ST_MARK  = 3'd4;  // writing a granted run
  localparam logic [2:0] ST_FIN   = 3'd5;  // hand result to output register

  logic [2:0] state_q, state_d;

  // configuration
  logic [AddrW-1:0] class_start_q [NumClass];
  logic [SizeW-1:0] largest_q;

  // scan registers
  logic [PW-1:0]    cur_q, cur_d;     // unit whose mark is in rdata_q (scan)
  logic [PW-1:0]    cand_q, cand_d;   // first unit of the candidate run
  logic [SizeW-1:0] cnt_q, cnt_d;     // free units found, or units left to mark
  logic [SizeW-1:0] size_q, size_d;
  logic             op_q, op_d;
  status_e          status_q, status_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  // mark store
  logic [1:0]    mark_mem_q [HEAP_UNITS];
  logic [1:0]    rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;
  logic [AW-1:0] rd_addr;

  // helpers
  logic [PW-1:0] nxt;
  logic [PW-1:0] start_pos;

  assign nxt       = cur_q + PW'(1);
  assign start_pos = PW'(class_start_q[size_class(in_data_i.request_size)]);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mark_mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mark_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClass; i++) begin
        class_start_q[i] <= '0;
      end
      largest_q <= SizeW'(64);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LARGEST_SIZE) begin
        largest_q <= cfg_data_i[SizeW-1:0];
      end else begin
        class_start_q[cfg_index_i] <= cfg_data_i[AddrW-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    size_d      = size_q;
    op_d        = op_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q[AW-1:0];
    wr_data     = MARK_FREE;
    rd_addr     = cur_q[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (cur_q == HeapLast) begin
          cur_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cur_d = nxt;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i.action;
          size_d   = in_data_i.request_size;
          status_d = STATUS_OK;
          state_d  = ST_FIN;
          if (in_data_i.action == ACT_ALLOC) begin
            if (in_data_i.request_size == '0 || in_data_i.request_size > largest_q ||
                in_data_i.request_size > MaxReq) begin
              status_d = STATUS_TOO_LARGE;
            end else if (start_pos + PW'(in_data_i.request_size) > HeapP) begin
              status_d = STATUS_NO_ROOM;
            end else begin
              cand_d  = start_pos;
              cur_d   = start_pos;
              cnt_d   = '0;
              state_d = ST_PRIME;
            end
          end else if (!in_data_i.address_present) begin
            status_d = STATUS_NULL_FREE;
          end else if (PW'(in_data_i.block_address) < HeapP) begin
            cur_d   = PW'(in_data_i.block_address);
            state_d = ST_PRIME;
          end
        end
      end

      ST_PRIME: begin
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        // read of the following unit is always under way
        rd_addr = nxt[AW-1:0];
        if (op_q == ACT_FREE) begin
          wr_en = 1'b1;
          if (rdata_q[MarkContBit] && nxt < HeapP) begin
            cur_d = nxt;
          end else begin
            state_d = ST_FIN;
          end
        end else if (rdata_q[MarkUsedBit]) begin
          // collision: restart just past the used unit
          if (nxt + PW'(size_q) > HeapP) begin
            status_d = STATUS_NO_ROOM;
            state_d  = ST_FIN;
          end else begin
            cand_d = nxt;
            cnt_d  = '0;
            cur_d  = nxt;
          end
        end else if (SizeW'(cnt_q + SizeW'(1)) == size_q) begin
          cnt_d   = size_q;
          cur_d   = cand_q;
          state_d = ST_MARK;
        end else begin
          cnt_d = SizeW'(cnt_q + SizeW'(1));
          cur_d = nxt;
        end
      end

      ST_MARK: begin
        wr_en   = 1'b1;
        wr_data = (cnt_q == SizeW'(1)) ? MARK_USED : MARK_USED_CONT;
        cnt_d   = SizeW'(cnt_q - SizeW'(1));
        cur_d   = nxt;
        if (cnt_q == SizeW'(1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_d.status = status_q;
          out_d.granted_address = (op_q == ACT_ALLOC && status_q == STATUS_OK) ?
                                  cand_q[AddrW-1:0] : '0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    cnt_q    <= cnt_d;
    size_q   <= size_d;
    op_q     <= op_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

endmodule
